>>> rtl/rau_pkg.sv
// Package with shared types and constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
  localparam int WORD_BITS = 32;
  localparam int CNT_BITS = $clog2(WORD_BITS + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD_START,
    ST_GCD_DIV,
    ST_GCD_STEP,
    ST_RED_N,
    ST_RED_N_DIV,
    ST_RED_D,
    ST_RED_D_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic comb;
    logic gcd_init;
    logic div_start;
    logic div_step;
    logic gcd_swap;
    logic red_n_init;
    logic red_n_store;
    logic red_d_init;
    logic red_d_store;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic skip_reduce;
    logic div_done;
    logic gcd_zero;
  } sts_t;
endpackage
`default_nettype wire

>>> rtl/rational_arith_unit_top.sv
// Top level of the rational arithmetic unit with output register.
//
//   channel  direction  signals
//   in       input      in_valid, in_ready, in_op, in_a_num, in_a_den, in_b_num, in_b_den
//   out      output     out_valid, out_ready, out_res_num, out_res_den
//
// Special cases and zero results skip the reduction; every other word runs
// the GCD loop and then both reducing divisions on the bit-serial restoring
// divider, which the GCD loop and both reducing divisions share.
// Reset is synchronous and active low.
// A new word is taken once the previous result has moved to the output register.
`default_nettype none
module rational_arith_unit_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_a_num,
  input  wire logic [31:0] in_a_den,
  input  wire logic [31:0] in_b_num,
  input  wire logic [31:0] in_b_den,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_res_num,
  output logic [31:0]      out_res_den
);
  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;
  logic busy, done, out_free;
  logic out_valid_r;
  logic [31:0] res_num_r, res_den_r;
  logic [rau_pkg::WORD_BITS-1:0] rn, rd;
  logic [63:0] en, ed;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !busy;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_valid), .out_free(out_free),
    .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  rau_dp u_dp (
    .clk(clk), .cmd(cmd), .op(in_op), .a_num(in_a_num), .a_den(in_a_den),
    .b_num(in_b_num), .b_den(in_b_den), .sts(sts), .rn(rn), .rd(rd)
  );

  assign en = {{(64-rau_pkg::WORD_BITS){rn[rau_pkg::WORD_BITS-1]}}, rn};
  assign ed = {{(64-rau_pkg::WORD_BITS){rd[rau_pkg::WORD_BITS-1]}}, rd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_num_r <= en[31:0];
      res_den_r <= ed[31:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
endmodule
`default_nettype wire

>>> rtl/rau_ctrl.sv
// Controller state machine sequencing the multiply, GCD and reduction steps.
`default_nettype none
module rau_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          out_free,
  input  wire rau_pkg::sts_t sts,
  output rau_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               done
);
  rau_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    done = 1'b0;
    busy = (state_r != rau_pkg::ST_IDLE);
    case (state_r)
      rau_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = rau_pkg::ST_MUL1;
        end
      end
      rau_pkg::ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = rau_pkg::ST_MUL2;
      end
      rau_pkg::ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = rau_pkg::ST_COMB;
      end
      rau_pkg::ST_COMB: begin
        cmd.comb = 1'b1;
        state_nxt = rau_pkg::ST_GCD_START;
      end
      rau_pkg::ST_GCD_START: begin
        if (sts.special || sts.skip_reduce) begin
          state_nxt = rau_pkg::ST_DONE;
        end else begin
          cmd.gcd_init = 1'b1;
          state_nxt = rau_pkg::ST_GCD_STEP;
        end
      end
      rau_pkg::ST_GCD_STEP: begin
        if (sts.gcd_zero) begin
          state_nxt = rau_pkg::ST_RED_N;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = rau_pkg::ST_GCD_DIV;
        end
      end
      rau_pkg::ST_GCD_DIV: begin
        if (sts.div_done) begin
          cmd.gcd_swap = 1'b1;
          state_nxt = rau_pkg::ST_GCD_STEP;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      rau_pkg::ST_RED_N: begin
        cmd.red_n_init = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = rau_pkg::ST_RED_N_DIV;
      end
      rau_pkg::ST_RED_N_DIV: begin
        if (sts.div_done) begin
          cmd.red_n_store = 1'b1;
          state_nxt = rau_pkg::ST_RED_D;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      rau_pkg::ST_RED_D: begin
        cmd.red_d_init = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = rau_pkg::ST_RED_D_DIV;
      end
      rau_pkg::ST_RED_D_DIV: begin
        if (sts.div_done) begin
          cmd.red_d_store = 1'b1;
          state_nxt = rau_pkg::ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      rau_pkg::ST_DONE: begin
        if (out_free) begin
          done = 1'b1;
          state_nxt = rau_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rau_pkg::ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/rau_dp.sv
// Datapath with operand registers, shared multiplier and a restoring divider.
`default_nettype none
module rau_dp (
  input  wire logic                       clk,
  input  wire rau_pkg::cmd_t              cmd,
  input  wire logic [1:0]                 op,
  input  wire logic [31:0]                a_num,
  input  wire logic [31:0]                a_den,
  input  wire logic [31:0]                b_num,
  input  wire logic [31:0]                b_den,
  output rau_pkg::sts_t                   sts,
  output logic [rau_pkg::WORD_BITS-1:0]   rn,
  output logic [rau_pkg::WORD_BITS-1:0]   rd
);
  localparam int W = rau_pkg::WORD_BITS;

  logic [1:0]   op_r;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic [W-1:0] p0_r, p1_r;
  logic [W-1:0] rn_r, rd_r;
  logic         special_r;
  logic [W-1:0] ga_r, gb_r;
  logic [W-1:0] dq_r, drem_r, dvs_r;
  logic [rau_pkg::CNT_BITS-1:0] dcnt_r;
  logic [W-1:0] mul_x, mul_y, mul_p;
  logic [W:0]   trial;
  logic [W-1:0] rem_sh;
  logic [W-1:0] mag_rn, mag_rd, sel_x;
  logic         a_nan, b_nan, az, bz, anz, bnz, neg_ab;
  logic [W-1:0] sp_n;
  logic         sp_is;

  function automatic logic [W-1:0] wrapf(input logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[W-1:0];
  endfunction

  function automatic logic [W-1:0] magf(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    mul_x = an_r;
    mul_y = bd_r;
    case (rau_pkg::op_t'(op_r))
      rau_pkg::OP_MUL: begin
        mul_x = cmd.mul1 ? an_r : ad_r;
        mul_y = cmd.mul1 ? bn_r : bd_r;
      end
      rau_pkg::OP_DIV: begin
        mul_x = cmd.mul1 ? an_r : ad_r;
        mul_y = cmd.mul1 ? bd_r : bn_r;
      end
      default: begin
        mul_x = cmd.mul1 ? an_r : (cmd.mul2 ? bn_r : ad_r);
        mul_y = cmd.mul1 ? bd_r : (cmd.mul2 ? ad_r : bd_r);
      end
    endcase
    mul_p = mul_x * mul_y;
  end

  always_comb begin
    a_nan = (an_r == '0) && (ad_r == '0);
    b_nan = (bn_r == '0) && (bd_r == '0);
    az = (ad_r == '0);
    bz = (bd_r == '0);
    anz = (an_r == '0);
    bnz = (bn_r == '0);
    neg_ab = an_r[W-1] ^ bn_r[W-1];
    sp_is = 1'b1;
    sp_n = '0;
    if (a_nan || b_nan) begin
      sp_n = '0;
    end else begin
      case (rau_pkg::op_t'(op_r))
        rau_pkg::OP_ADD: begin
          sp_is = az || bz;
          sp_n = W'(1);
        end
        rau_pkg::OP_SUB: begin
          sp_is = az || bz;
          sp_n = (az && bz) ? '0 : (az ? W'(1) : '1);
        end
        rau_pkg::OP_MUL: begin
          sp_is = az || bz;
          if ((az && bnz) || (anz && bz)) begin
            sp_n = '0;
          end else begin
            sp_n = neg_ab ? '1 : W'(1);
          end
        end
        default: begin
          if ((anz && bnz) || (az && bz)) begin
            sp_is = 1'b1;
            sp_n = '0;
          end else begin
            sp_is = az || bnz;
            sp_n = an_r[W-1] ? '1 : W'(1);
          end
        end
      endcase
    end
  end

  assign mag_rn = magf(rn_r);
  assign mag_rd = magf(rd_r);
  assign rem_sh = {drem_r[W-2:0], dq_r[W-1]};
  assign trial = {drem_r, dq_r[W-1]} - {1'b0, dvs_r};
  assign sel_x = cmd.red_n_init ? mag_rn : (cmd.red_d_init ? mag_rd : ga_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op;
      an_r <= wrapf(a_num);
      ad_r <= wrapf(a_den);
      bn_r <= wrapf(b_num);
      bd_r <= wrapf(b_den);
    end
    if (cmd.mul1) begin
      p0_r <= mul_p;
    end
    if (cmd.mul2) begin
      p1_r <= mul_p;
    end
    if (cmd.comb) begin
      special_r <= sp_is || a_nan || b_nan;
      if (sp_is || a_nan || b_nan) begin
        rn_r <= sp_n;
        rd_r <= '0;
      end else begin
        case (rau_pkg::op_t'(op_r))
          rau_pkg::OP_ADD: rn_r <= p0_r + p1_r;
          rau_pkg::OP_SUB: rn_r <= p0_r - p1_r;
          default:         rn_r <= p0_r;
        endcase
        rd_r <= (op_r[1]) ? p1_r : mul_p;
      end
    end
    if (cmd.gcd_init) begin
      ga_r <= (mag_rd > mag_rn) ? mag_rd : mag_rn;
      gb_r <= (mag_rd > mag_rn) ? mag_rn : mag_rd;
    end
    if (cmd.div_start) begin
      dq_r <= sel_x;
      drem_r <= '0;
      dvs_r <= (cmd.red_n_init || cmd.red_d_init) ? ga_r : gb_r;
      dcnt_r <= rau_pkg::CNT_BITS'(W);
    end else if (cmd.div_step) begin
      if (!trial[W]) begin
        drem_r <= trial[W-1:0];
        dq_r <= {dq_r[W-2:0], 1'b1};
      end else begin
        drem_r <= rem_sh;
        dq_r <= {dq_r[W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd.gcd_swap) begin
      ga_r <= gb_r;
      gb_r <= drem_r;
    end
    if (cmd.red_n_store) begin
      rn_r <= rn_r[W-1] ? (~dq_r + 1'b1) : dq_r;
    end
    if (cmd.red_d_store) begin
      rd_r <= rd_r[W-1] ? (~dq_r + 1'b1) : dq_r;
    end
  end

  assign sts.special = special_r;
  assign sts.skip_reduce = (rn_r == '0) || (rd_r == '0);
  assign sts.div_done = (dcnt_r == '0);
  assign sts.gcd_zero = (gb_r == '0);
  assign rn = rn_r;
  assign rd = rd_r;
endmodule
`default_nettype wire
